// File: hdl/assert_macros.svh
// Assertion macros, included by the top level triangle_face_normal.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TFN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define TFN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TFN_ASSERT(lbl, clk, rst_n, prop)
`define TFN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/tfn_pkg.sv
// Shared constants and types of the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;
    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int M_W         = 31;
    localparam int SQ_W        = 2 * M_W;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 48;
    localparam int DVS_W       = ROOT_W + 1;
    localparam int Q_W         = NORMAL_FRAC_BITS + 1;
    localparam int OUT_W       = 16;
    localparam int SH_W        = 6;
    localparam int BIT_W       = 4;
    localparam int NORM_STAGES = 6;
    localparam int SQRT_STAGES = 32;

    typedef logic [8:0][COORD_WIDTH-1:0] vtx_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } nrm_t;

    typedef struct packed {
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                degen;
    } pay_t;

    typedef struct packed {
        logic [SUM_W-1:0] x;
        logic [SUM_W-1:0] res;
        pay_t             pay;
    } sq_t;

    typedef struct packed {
        logic [2:0][REM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   q;
        logic [DVS_W-1:0]      dvs;
        logic [2:0]            neg;
        logic                  degen;
    } dv_t;
endpackage
`default_nettype wire

// File: hdl/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
// Takes one triangle per clock while s_ready is high and returns its unit face
// normal in signed Q1.14 after the edge, partial product and cross product
// registers, 6 normalize cells, the square and sum registers, 32 square root
// cells (one root bit each), the divide setup register, 15 divide cells (one
// quotient bit each) and the output register. The pipeline stalls as a whole
// only while a result waits on m_ready. A zero cross product gives degenerate = 1 and a zero normal.
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_v0_x,
    input  wire logic signed [15:0] s_v0_y,
    input  wire logic signed [15:0] s_v0_z,
    input  wire logic signed [15:0] s_v1_x,
    input  wire logic signed [15:0] s_v1_y,
    input  wire logic signed [15:0] s_v1_z,
    input  wire logic signed [15:0] s_v2_x,
    input  wire logic signed [15:0] s_v2_y,
    input  wire logic signed [15:0] s_v2_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_normal_x,
    output logic signed [15:0]      m_normal_y,
    output logic signed [15:0]      m_normal_z,
    output logic                    m_degenerate
);
    localparam int NS = tfn_pkg::NORM_STAGES;
    localparam int RS = tfn_pkg::SQRT_STAGES;
    localparam int DS = tfn_pkg::Q_W;

    logic          adv;
    tfn_pkg::vtx_t vtx;
    tfn_pkg::nrm_t nrm_bus [NS+1];
    logic          nrm_vld [NS+1];
    tfn_pkg::sq_t  sq_bus  [RS+1];
    logic          sq_vld  [RS+1];
    tfn_pkg::dv_t  dv_bus  [DS+1];
    logic          dv_vld  [DS+1];

    logic [2:0][tfn_pkg::SQ_W-1:0] sqr_reg, sqr_next;
    tfn_pkg::pay_t pay_reg, pay_next;
    logic          sqr_vld_reg, sum_vld_reg, dvi_vld_reg;
    tfn_pkg::sq_t  sum_reg, sum_next;
    tfn_pkg::dv_t  dvi_reg, dvi_next;
    logic [tfn_pkg::ROOT_W-1:0] root;

    logic                      m_valid_reg, m_valid_next;
    logic [2:0][tfn_pkg::OUT_W-1:0] nrm_out_reg, nrm_out_next;
    logic                      degen_reg, degen_next;

    // Advance the whole pipeline unless a result is stuck at the output
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    assign vtx = {s_v2_z, s_v2_y, s_v2_x, s_v1_z, s_v1_y, s_v1_x,
                  s_v0_z, s_v0_y, s_v0_x};

    tfn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .vtx       (vtx),
        .out_valid (nrm_vld[0]),
        .out_data  (nrm_bus[0])
    );

    // Normalize so the largest magnitude sits at the top bit
    for (genvar k = 0; k < NS; k++) begin : g_norm
        tfn_norm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (nrm_vld[k]),
            .shift     (tfn_pkg::SH_W'(1 << (NS - 1 - k))),
            .in_data   (nrm_bus[k]),
            .out_valid (nrm_vld[k+1]),
            .out_data  (nrm_bus[k+1])
        );
    end

    // Square the scaled components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pay_next.m[i] = nrm_bus[NS].mag[i][tfn_pkg::MAG_W-1 -: tfn_pkg::M_W];
            sqr_next[i]   = pay_next.m[i] * pay_next.m[i];
        end
        pay_next.neg   = nrm_bus[NS].neg;
        pay_next.degen = nrm_bus[NS].degen;
    end

    // Sum the squares and seed the root
    always_comb begin
        sum_next.x   = tfn_pkg::SUM_W'(sqr_reg[0]) + tfn_pkg::SUM_W'(sqr_reg[1]) +
                       tfn_pkg::SUM_W'(sqr_reg[2]);
        sum_next.res = '0;
        sum_next.pay = pay_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqr_reg  <= sqr_next;
            pay_reg  <= pay_next;
            sum_reg  <= sum_next;
            dvi_reg  <= dvi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqr_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            dvi_vld_reg <= 1'b0;
        end else if (adv) begin
            sqr_vld_reg <= nrm_vld[NS];
            sum_vld_reg <= sqr_vld_reg;
            dvi_vld_reg <= sq_vld[RS];
        end
    end

    assign sq_bus[0] = sum_reg;
    assign sq_vld[0] = sum_vld_reg;

    // Integer square root, one bit per cell
    for (genvar k = 0; k < RS; k++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (sq_vld[k]),
            .one       (tfn_pkg::SUM_W'(64'd1 << (tfn_pkg::SUM_W - 2 - 2 * k))),
            .in_data   (sq_bus[k]),
            .out_valid (sq_vld[k+1]),
            .out_data  (sq_bus[k+1])
        );
    end

    // Set up dividend with rounding term and doubled divisor
    always_comb begin
        root = sq_bus[RS].res[tfn_pkg::ROOT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            dvi_next.rem[i] = (tfn_pkg::REM_W'(sq_bus[RS].pay.m[i]) <<
                               (tfn_pkg::NORMAL_FRAC_BITS + 1)) + tfn_pkg::REM_W'(root);
            dvi_next.q[i]   = '0;
        end
        dvi_next.dvs   = tfn_pkg::DVS_W'(root) << 1;
        dvi_next.neg   = sq_bus[RS].pay.neg;
        dvi_next.degen = sq_bus[RS].pay.degen;
    end

    assign dv_bus[0] = dvi_reg;
    assign dv_vld[0] = dvi_vld_reg;

    // Restoring division, one quotient bit per cell
    for (genvar k = 0; k < DS; k++) begin : g_div
        tfn_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (dv_vld[k]),
            .bit_idx   (tfn_pkg::BIT_W'(DS - 1 - k)),
            .in_data   (dv_bus[k]),
            .out_valid (dv_vld[k+1]),
            .out_data  (dv_bus[k+1])
        );
    end

    // Clamp, apply sign and force degenerate results to zero
    always_comb begin
        logic [tfn_pkg::Q_W-1:0]   n;
        logic [tfn_pkg::OUT_W-1:0] nx;
        n  = '0;
        nx = '0;
        for (int i = 0; i < 3; i++) begin
            n = dv_bus[DS].q[i];
            if (n > tfn_pkg::Q_W'(1 << tfn_pkg::NORMAL_FRAC_BITS)) begin
                n = tfn_pkg::Q_W'(1 << tfn_pkg::NORMAL_FRAC_BITS);
            end
            nx = tfn_pkg::OUT_W'(n);
            if (dv_bus[DS].degen) begin
                nrm_out_next[i] = '0;
            end else if (dv_bus[DS].neg[i]) begin
                nrm_out_next[i] = ~nx + 1'b1;
            end else begin
                nrm_out_next[i] = nx;
            end
        end
        degen_next   = dv_bus[DS].degen;
        m_valid_next = dv_vld[DS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nrm_out_reg <= nrm_out_next;
            degen_reg   <= degen_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_normal_x   = nrm_out_reg[0];
    assign m_normal_y   = nrm_out_reg[1];
    assign m_normal_z   = nrm_out_reg[2];
    assign m_degenerate = degen_reg;

    // Degenerate transaction carries a zero normal
    `TFN_ASSERT(a_degen_zero, aclk, aresetn, (m_valid && m_degenerate) |-> (nrm_out_reg == '0))
    // Regular transaction never carries an all-zero normal
    `TFN_ASSERT(a_nonzero, aclk, aresetn, (m_valid && !m_degenerate) |-> (nrm_out_reg != '0))
    // Components stay within unit range
    `TFN_ASSERT(a_range_x, aclk, aresetn, m_valid |-> (m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384))
    `TFN_ASSERT(a_range_y, aclk, aresetn, m_valid |-> (m_normal_y <= 16'sd16384 && m_normal_y >= -16'sd16384))
    `TFN_ASSERT(a_range_z, aclk, aresetn, m_valid |-> (m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384))
endmodule
`default_nettype wire

// File: hdl/tfn_front.sv
// Edge, cross product and sign-magnitude stages of the face normal pipeline.
`default_nettype none
module tfn_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire tfn_pkg::vtx_t vtx,
    output logic              out_valid,
    output tfn_pkg::nrm_t     out_data
);
    logic signed [2:0][tfn_pkg::EDGE_W-1:0] e1_reg, e1_next, e2_reg, e2_next;
    logic signed [5:0][tfn_pkg::PROD_W-1:0] prod_reg, prod_next;
    tfn_pkg::nrm_t nrm_reg, nrm_next;
    logic [2:0] vld_reg, vld_next;

    // Form both edges from vertex 0
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1_next[i] = tfn_pkg::EDGE_W'($signed(vtx[3+i])) -
                         tfn_pkg::EDGE_W'($signed(vtx[i]));
            e2_next[i] = tfn_pkg::EDGE_W'($signed(vtx[6+i])) -
                         tfn_pkg::EDGE_W'($signed(vtx[i]));
        end
    end

    // Take the six partial products of the cross product
    always_comb begin
        prod_next[0] = $signed(e1_reg[1]) * $signed(e2_reg[2]);
        prod_next[1] = $signed(e1_reg[2]) * $signed(e2_reg[1]);
        prod_next[2] = $signed(e1_reg[2]) * $signed(e2_reg[0]);
        prod_next[3] = $signed(e1_reg[0]) * $signed(e2_reg[2]);
        prod_next[4] = $signed(e1_reg[0]) * $signed(e2_reg[1]);
        prod_next[5] = $signed(e1_reg[1]) * $signed(e2_reg[0]);
    end

    // Subtract and split into sign and magnitude
    always_comb begin
        logic signed [tfn_pkg::CROSS_W-1:0] c;
        logic [tfn_pkg::CROSS_W-1:0] a;
        c = '0;
        a = '0;
        for (int i = 0; i < 3; i++) begin
            c = tfn_pkg::CROSS_W'($signed(prod_reg[2*i])) -
                tfn_pkg::CROSS_W'($signed(prod_reg[2*i+1]));
            a = c[tfn_pkg::CROSS_W-1] ? (~c + 1'b1) : c;
            nrm_next.neg[i] = c[tfn_pkg::CROSS_W-1];
            nrm_next.mag[i] = a[tfn_pkg::MAG_W-1:0];
        end
        nrm_next.degen = (nrm_next.mag[0] == '0) && (nrm_next.mag[1] == '0) &&
                         (nrm_next.mag[2] == '0);
    end

    assign vld_next = {vld_reg[1:0], in_valid};

    // Advance the valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            prod_reg <= prod_next;
            nrm_reg  <= nrm_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = nrm_reg;
endmodule
`default_nettype wire

// File: hdl/tfn_norm_cell.sv
// One normalize cell: shifts all three magnitudes left when the top bits are clear.
`default_nettype none
module tfn_norm_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     adv,
    input  wire logic                     in_valid,
    input  wire logic [tfn_pkg::SH_W-1:0] shift,
    input  wire tfn_pkg::nrm_t            in_data,
    output logic                          out_valid,
    output tfn_pkg::nrm_t                 out_data
);
    logic [tfn_pkg::MAG_W-1:0] any_bits;
    logic [tfn_pkg::MAG_W-1:0] top_bits;
    logic                      take;
    tfn_pkg::nrm_t             data_reg, data_next;
    logic                      vld_reg;

    // Shift when the top shift bits of every magnitude are zero
    always_comb begin
        any_bits  = in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
        top_bits  = any_bits >> (tfn_pkg::MAG_W - int'(shift));
        take      = (top_bits == '0);
        data_next = in_data;
        if (take) begin
            for (int i = 0; i < 3; i++) begin
                data_next.mag[i] = in_data.mag[i] << shift;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// File: hdl/tfn_sqrt_cell.sv
// One square root cell: resolves one result bit of the integer square root.
`default_nettype none
module tfn_sqrt_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [tfn_pkg::SUM_W-1:0] one,
    input  wire tfn_pkg::sq_t              in_data,
    output logic                           out_valid,
    output tfn_pkg::sq_t                   out_data
);
    logic [tfn_pkg::SUM_W-1:0] trial;
    tfn_pkg::sq_t              data_reg, data_next;
    logic                      vld_reg;

    // Subtract the trial value when it fits
    always_comb begin
        trial     = in_data.res + one;
        data_next = in_data;
        if (in_data.x >= trial) begin
            data_next.x   = in_data.x - trial;
            data_next.res = (in_data.res >> 1) + one;
        end else begin
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// File: hdl/tfn_div_cell.sv
// One divide cell: resolves one quotient bit for all three components.
`default_nettype none
module tfn_div_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [tfn_pkg::BIT_W-1:0] bit_idx,
    input  wire tfn_pkg::dv_t              in_data,
    output logic                           out_valid,
    output tfn_pkg::dv_t                   out_data
);
    logic [tfn_pkg::REM_W-1:0] sub;
    tfn_pkg::dv_t              data_reg, data_next;
    logic                      vld_reg;

    // Compare each remainder against the shifted divisor
    always_comb begin
        sub       = tfn_pkg::REM_W'(in_data.dvs) << bit_idx;
        data_next = in_data;
        for (int i = 0; i < 3; i++) begin
            if (in_data.rem[i] >= sub) begin
                data_next.rem[i] = in_data.rem[i] - sub;
                data_next.q[i]   = {in_data.q[i][tfn_pkg::Q_W-2:0], 1'b1};
            end else begin
                data_next.q[i]   = {in_data.q[i][tfn_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire
